// ===== rtl/core/bfca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfca_pkg
// shared constants, types and helpers of the best-fit chunk allocator
// ----------------------------------------------------------------------------
package bfca_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_BITS   = 32;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_LAST  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_MEM    = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE = 3'd4;

    localparam logic [9:0] MAX_REQ = 10'd512;

    localparam logic [0:0] REG_HEAP_BASE  = 1'd0;
    localparam logic [0:0] REG_HEAP_LIMIT = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic start;    // latch command, clear scan state
        logic scan;     // examine entry at scan index
        logic finish;   // decide, update table, load result
    } bfca_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic last_entry;
        logic stop_early;
    } bfca_stat_t;

    function automatic logic [9:0] class_bytes(input logic [2:0] cls);
        logic [10:0] b;
        b = 11'd32 << cls;
        return b[9:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/best_fit_chunk_allocator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_chunk_allocator_core
// best-fit chunk allocator with size classes, stream command interface
// ----------------------------------------------------------------------------
// The sequencer walks the chunk table one entry per cycle through a
// registered memory read, drains the compare stage, sees the end of the
// table, then decides and writes back in its finish state. A free by address
// stops early after its first match, and an unused command code ends at once.
// One command is in work at a time; the next one enters at the earliest in
// the cycle its predecessor's result is taken, and a result that is not
// taken holds off the input.
module best_fit_chunk_allocator_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // cmd[1:0], req_size[11:2], address[43:12], zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // status[2:0], chunk_address[34:3],
                                        // chunk_size[44:35], reused[45], zero
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    bfca_pkg::bfca_ctrl_t ctrl;
    bfca_pkg::bfca_stat_t stat;
    logic [2:0]  res_status;
    logic [31:0] res_addr;
    logic [9:0]  res_size;
    logic        res_reused;

    bfca_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .stat(stat), .ctrl(ctrl)
    );

    bfca_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .in_cmd(s_tdata[1:0]), .in_size(s_tdata[11:2]), .in_addr(s_tdata[43:12]),
        .cfg_we(cfg_we), .cfg_index(cfg_index[0]), .cfg_hi(1'b0), .cfg_data(cfg_data),
        .res_status(res_status), .res_addr(res_addr),
        .res_size(res_size), .res_reused(res_reused)
    );

    assign m_tdata = {2'b00, res_reused, res_size, res_addr, res_status};

`ifndef ASSERT_OFF
    // no new command while a result waits and is not taken
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("command accepted over a pending result");
    // a result appears only after a finish cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ctrl.finish))
        else $error("result without finish");
    // errors carry no chunk
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != bfca_pkg::ST_OK) |-> (m_tdata[45:3] == '0))
        else $error("error result with payload");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bfca_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfca_ctrl
// command sequencer: accept, scan the table, finish, present result
// ----------------------------------------------------------------------------
module bfca_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire bfca_pkg::bfca_stat_t stat,
    output bfca_pkg::bfca_ctrl_t  ctrl
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   busy;

    // next item enters once the waiting result is taken, at the earliest in the same cycle
    assign busy      = (state_reg != S_IDLE);
    assign in_ready  = !busy && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb begin
        ctrl.start  = in_valid && in_ready;
        ctrl.scan   = (state_reg == S_SCAN);
        ctrl.finish = (state_reg == S_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready) state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    if (stat.last_entry || stat.stop_early) state_reg <= S_DONE;
                end
                S_DONE: begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bfca_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfca_dp
// chunk table, scan registers, break pointer and result register
// ----------------------------------------------------------------------------
module bfca_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bfca_pkg::bfca_ctrl_t ctrl,
    output bfca_pkg::bfca_stat_t      stat,
    input  wire logic [1:0]           in_cmd,
    input  wire logic [9:0]           in_size,
    input  wire logic [31:0]          in_addr,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic                 cfg_hi,
    input  wire logic [31:0]          cfg_data,
    output logic [2:0]                res_status,
    output logic [31:0]               res_addr,
    output logic [9:0]                res_size,
    output logic                      res_reused
);

    localparam int IB = bfca_pkg::IDX_BITS;
    localparam int AB = bfca_pkg::ADDR_BITS;
    localparam int D  = bfca_pkg::TABLE_DEPTH;

    // flag arrays: valid bits and in-use bits in flip-flops
    logic [D-1:0] valid_reg;
    logic [D-1:0] in_use_reg;

    // payload memory: base, class, stamp
    logic [AB-1:0] base_mem  [D];
    logic [2:0]    class_mem [D];
    logic [31:0]   stamp_mem [D];

    logic [31:0]   stamp_cnt_reg;
    logic [AB-1:0] heap_break_reg;
    logic [31:0]   heap_limit_reg;

    logic [1:0]    cmd_reg;
    logic [9:0]    size_reg;
    logic [AB-1:0] addr_reg;

    // scan: address counter, registered read, pipelined compare
    logic [bfca_pkg::CNT_BITS-1:0] rd_cnt_reg;
    logic          rd_v_reg;
    logic [IB-1:0] rd_idx_reg;
    logic [AB-1:0] rd_base_reg;
    logic [2:0]    rd_class_reg;
    logic [31:0]   rd_stamp_reg;
    logic          rd_valid_reg, rd_in_use_reg;

    logic          hit_reg;
    logic [IB-1:0] hit_idx_reg;
    logic [2:0]    hit_class_reg;
    logic [31:0]   hit_stamp_reg;
    logic [AB-1:0] hit_base_reg;
    logic          slot_reg;
    logic [IB-1:0] slot_idx_reg;

    logic [2:0] req_cls;
    always_comb begin
        req_cls = 3'd4;
        for (int c = 4; c >= 0; c--) begin
            if (bfca_pkg::class_bytes(3'(c)) >= size_reg) req_cls = 3'(c);
        end
    end

    logic [AB:0]  carve_end;
    logic [9:0]   carve_bytes;
    logic         no_mem;
    assign carve_bytes = bfca_pkg::class_bytes(req_cls);
    assign carve_end   = {1'b0, heap_break_reg} + (AB+1)'(carve_bytes);
    assign no_mem      = carve_end[AB] || (carve_end > (AB+1)'(heap_limit_reg));

    logic take;
    always_comb begin
        take = 1'b0;
        if (rd_v_reg && rd_valid_reg && rd_in_use_reg == (cmd_reg != bfca_pkg::CMD_ALLOC)) begin
            case (cmd_reg)
                bfca_pkg::CMD_ALLOC:
                    take = (bfca_pkg::class_bytes(rd_class_reg) >= size_reg) &&
                           (!hit_reg || rd_class_reg < hit_class_reg ||
                            (rd_class_reg == hit_class_reg && rd_stamp_reg < hit_stamp_reg));
                bfca_pkg::CMD_FREE:
                    take = !hit_reg && (rd_base_reg == addr_reg);
                bfca_pkg::CMD_LAST:
                    take = !hit_reg || rd_stamp_reg > hit_stamp_reg;
                default: take = 1'b0;
            endcase
        end
    end

    assign stat.last_entry = (rd_cnt_reg == bfca_pkg::CNT_BITS'(D)) && !rd_v_reg;
    assign stat.stop_early = (cmd_reg == bfca_pkg::CMD_FREE && hit_reg) ||
                             (cmd_reg != bfca_pkg::CMD_FREE && cmd_reg != bfca_pkg::CMD_ALLOC &&
                              cmd_reg != bfca_pkg::CMD_LAST);

    logic [IB-1:0] rd_idx;
    assign rd_idx = rd_cnt_reg[IB-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.scan && rd_cnt_reg != bfca_pkg::CNT_BITS'(D)) begin
            rd_base_reg  <= base_mem[rd_idx];
            rd_class_reg <= class_mem[rd_idx];
            rd_stamp_reg <= stamp_mem[rd_idx];
        end
        if (ctrl.finish) begin
            if (hit_reg) begin
                stamp_mem[hit_idx_reg] <= stamp_cnt_reg;
            end else if (cmd_reg == bfca_pkg::CMD_ALLOC && size_reg <= bfca_pkg::MAX_REQ &&
                         !no_mem && slot_reg) begin
                base_mem[slot_idx_reg]  <= heap_break_reg;
                class_mem[slot_idx_reg] <= req_cls;
                stamp_mem[slot_idx_reg] <= stamp_cnt_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            in_use_reg     <= '0;
            stamp_cnt_reg  <= '0;
            heap_break_reg <= '0;
            heap_limit_reg <= '1;
            rd_cnt_reg     <= '0;
            rd_v_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            slot_reg       <= 1'b0;
        end else begin
            if (cfg_we && !cfg_hi && cfg_index == bfca_pkg::REG_HEAP_BASE)
                heap_break_reg <= AB'(cfg_data);
            if (cfg_we && !cfg_hi && cfg_index == bfca_pkg::REG_HEAP_LIMIT)
                heap_limit_reg <= cfg_data;
            if (ctrl.start) begin
                cmd_reg    <= in_cmd;
                size_reg   <= in_size;
                addr_reg   <= AB'(in_addr);
                rd_cnt_reg <= '0;
                rd_v_reg   <= 1'b0;
                hit_reg    <= 1'b0;
                slot_reg   <= 1'b0;
            end
            if (ctrl.scan) begin
                if (rd_cnt_reg != bfca_pkg::CNT_BITS'(D)) begin
                    rd_cnt_reg    <= rd_cnt_reg + 1'b1;
                    rd_idx_reg    <= rd_idx;
                    rd_valid_reg  <= valid_reg[rd_idx];
                    rd_in_use_reg <= in_use_reg[rd_idx];
                    rd_v_reg      <= 1'b1;
                end else begin
                    rd_v_reg <= 1'b0;
                end
                if (take) begin
                    hit_reg       <= 1'b1;
                    hit_idx_reg   <= rd_idx_reg;
                    hit_class_reg <= rd_class_reg;
                    hit_stamp_reg <= rd_stamp_reg;
                    hit_base_reg  <= rd_base_reg;
                end
                if (rd_v_reg && !rd_valid_reg && !slot_reg) begin
                    slot_reg     <= 1'b1;
                    slot_idx_reg <= rd_idx_reg;
                end
            end
            if (ctrl.finish) begin
                if (cmd_reg == bfca_pkg::CMD_ALLOC && size_reg > bfca_pkg::MAX_REQ) begin
                    res_status <= bfca_pkg::ST_TOO_LARGE;
                    res_addr   <= '0;
                    res_size   <= '0;
                    res_reused <= 1'b0;
                end else if (hit_reg) begin
                    in_use_reg[hit_idx_reg] <= (cmd_reg == bfca_pkg::CMD_ALLOC);
                    stamp_cnt_reg <= stamp_cnt_reg + 1'b1;
                    res_status <= bfca_pkg::ST_OK;
                    res_addr   <= 32'(hit_base_reg);
                    res_size   <= bfca_pkg::class_bytes(hit_class_reg);
                    res_reused <= (cmd_reg == bfca_pkg::CMD_ALLOC);
                end else if (cmd_reg != bfca_pkg::CMD_ALLOC) begin
                    res_status <= bfca_pkg::ST_NOT_ALLOC;
                    res_addr   <= '0;
                    res_size   <= '0;
                    res_reused <= 1'b0;
                end else if (no_mem) begin
                    res_status <= bfca_pkg::ST_NO_MEM;
                    res_addr   <= '0;
                    res_size   <= '0;
                    res_reused <= 1'b0;
                end else if (!slot_reg) begin
                    res_status <= bfca_pkg::ST_FULL;
                    res_addr   <= '0;
                    res_size   <= '0;
                    res_reused <= 1'b0;
                end else begin
                    valid_reg[slot_idx_reg]  <= 1'b1;
                    in_use_reg[slot_idx_reg] <= 1'b1;
                    stamp_cnt_reg  <= stamp_cnt_reg + 1'b1;
                    heap_break_reg <= carve_end[AB-1:0];
                    res_status <= bfca_pkg::ST_OK;
                    res_addr   <= 32'(heap_break_reg);
                    res_size   <= carve_bytes;
                    res_reused <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire
